// ----- hdl/c3sbf_pkg.sv -----
// Shared types and constants of the 3x3 sharpen and box blur filter.
`default_nettype none

package c3sbf_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Kernel arithmetic: a sum of nine channels needs 12 bits.
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 13;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int BLUR_SHIFT = 16;
  // floor(x * 7282 / 65536) equals floor(x / 9) for every sum of nine bytes.
  localparam logic [RECIP_W-1:0] BLUR_RECIP = 13'd7282;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COLOR    = 2'd3;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_DRAIN   = 1'b1;
  localparam logic MODE_SHARPEN = 1'b0;
  localparam logic MODE_BLUR    = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [CH_W-1:0] MAX_COLOR_RESET    = 8'd255;
  localparam int              MIN_DIM            = 3;
  localparam int              MAX_HEIGHT         = 4096;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t pixel;
    logic   frame_end;
  } result_t;

  // Up to two results enter the output queue together.
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

// ----- hdl/conv3x3_sharpen_blur_filter.sv -----
// Top level of the 3x3 sharpen and box blur filter over an RGB pixel stream.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    kind, in_red, in_green, in_blue
//   out      source     out_valid / out_ready  out_red, out_green, out_blue, frame_end
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is accepted per cycle unless the input stalls. A pixel reads
// both line buffers at acceptance; in the work stage, once the queue has
// room, the window shifts, the kernels run and the results enter a
// four-entry output queue. A request producing two results occupies the
// output port for two transfers; the input stalls only while the queue lacks room.
// Reset clears the counters, the window and the queue, not the line buffers.
`default_nettype none

module conv3x3_sharpen_blur_filter import c3sbf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  kind,
  input  wire logic [CH_W-1:0]       in_red,
  input  wire logic [CH_W-1:0]       in_green,
  input  wire logic [CH_W-1:0]       in_blue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [CH_W-1:0]       out_red,
  output logic      [CH_W-1:0]       out_green,
  output logic      [CH_W-1:0]       out_blue,
  output logic                       frame_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            filter_mode;
  logic [CH_W-1:0] max_color;

  // Frame position.
  logic [AW-1:0]    column_index;
  logic [ROW_W-1:0] row_index;
  logic [AW-1:0]    drain_index;
  logic             draining;
  logic [AW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;

  // Work stage.
  logic          s1_valid;
  logic          s1_kind;
  logic [AW-1:0] s1_col;
  pixel_t        s1_px;
  logic          s1_emit_a;
  logic          s1_filt;
  logic          s1_emit_b;
  logic          s1_last;
  logic [1:0]    s1_n;
  logic          s1_go;

  pixel_t window [9];
  pixel_t window_next [9];
  pixel_t up_rdata;
  pixel_t mid_rdata;
  pixel_t filtered;

  logic    accept;
  logic    is_drain;
  logic    take;
  logic    geom_write;
  push_t   push;
  result_t head;
  logic [FIFO_CW-1:0] free_slots;
  logic [AW-1:0]      mid_raddr;
  logic               ram_we;

  assign cfg_ready = 1'b1;

  // Width and height in use, clamped, minus one.
  always_comb begin
    if (32'(frame_width) < MIN_DIM) begin
      col_last = AW'(MIN_DIM - 1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      col_last = AW'(MAX_WIDTH - 1);
    end else begin
      col_last = AW'(frame_width - FW_W'(1));
    end
    if (32'(frame_height) < MIN_DIM) begin
      row_last = ROW_W'(MIN_DIM - 1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(frame_height - FH_W'(1));
    end
  end

  assign geom_write = cfg_valid && cfg_ready &&
                      (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      filter_mode  <= MODE_SHARPEN;
      max_color    <= MAX_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        REG_FILTER_MODE:  filter_mode  <= cfg_data[0];
        REG_MAX_COLOR:    max_color    <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixels while draining and drain requests outside a drain are dropped here.
  assign accept   = in_valid && in_ready;
  assign is_drain = (kind == KIND_DRAIN);
  assign take     = accept && (is_drain ? draining : !draining);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      drain_index  <= '0;
      draining     <= 1'b0;
    end else if (geom_write) begin
      column_index <= '0;
      row_index    <= '0;
      drain_index  <= '0;
      draining     <= 1'b0;
    end else if (take) begin
      if (is_drain) begin
        if (drain_index == col_last) begin
          drain_index <= '0;
          draining    <= 1'b0;
        end else begin
          drain_index <= drain_index + AW'(1);
        end
      end else if (column_index == col_last) begin
        column_index <= '0;
        if (row_index == row_last) begin
          row_index   <= '0;
          draining    <= 1'b1;
          drain_index <= '0;
        end else begin
          row_index <= row_index + ROW_W'(1);
        end
      end else begin
        column_index <= column_index + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_kind   <= kind;
      s1_col    <= column_index;
      s1_px     <= {in_red, in_green, in_blue};
      s1_emit_a <= (row_index >= ROW_W'(1)) && (column_index >= AW'(1));
      s1_filt   <= (row_index >= ROW_W'(2)) && (column_index >= AW'(2));
      s1_emit_b <= (row_index >= ROW_W'(1)) && (column_index == col_last);
      s1_last   <= (drain_index == col_last);
    end
  end

  // Line buffers: upper takes the old middle entry, middle takes the new pixel.
  assign mid_raddr = is_drain ? drain_index : column_index;
  assign ram_we    = s1_go && (s1_kind == KIND_PIXEL);

  c3sbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (mid_rdata),
    .re    (accept),
    .raddr (column_index),
    .rdata (up_rdata)
  );

  c3sbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (s1_px),
    .re    (accept),
    .raddr (mid_raddr),
    .rdata (mid_rdata)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r*3]     = window[r*3 + 1];
      window_next[r*3 + 1] = window[r*3 + 2];
    end
    window_next[2] = up_rdata;
    window_next[5] = mid_rdata;
    window_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        window[k] <= '0;
      end
    end else if (ram_we) begin
      window <= window_next;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic [8:0][CH_W-1:0] taps;

    always_comb begin
      for (int k = 0; k < 9; k++) begin
        taps[k] = window_next[k][(2 - ch) * CH_W +: CH_W];
      end
    end

    c3sbf_kernel u_kernel (
      .taps      (taps),
      .mode      (filter_mode),
      .max_color (max_color),
      .result    (filtered[(2 - ch) * CH_W +: CH_W])
    );
  end

  always_comb begin
    if (s1_kind == KIND_DRAIN) begin
      s1_n = 2'd1;
    end else if (s1_emit_a) begin
      s1_n = s1_emit_b ? 2'd2 : 2'd1;
    end else begin
      s1_n = 2'd0;
    end
  end

  assign s1_go = s1_valid && (free_slots >= FIFO_CW'(s1_n));

  always_comb begin
    push.n = s1_go ? s1_n : 2'd0;
    if (s1_kind == KIND_DRAIN) begin
      push.first = '{pixel: mid_rdata, frame_end: s1_last};
    end else begin
      push.first = '{pixel: (s1_filt ? filtered : window_next[4]), frame_end: 1'b0};
    end
    push.second = '{pixel: window_next[5], frame_end: 1'b0};
  end

  c3sbf_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .free_slots (free_slots)
  );

  assign out_red   = head.pixel[2*CH_W +: CH_W];
  assign out_green = head.pixel[CH_W +: CH_W];
  assign out_blue  = head.pixel[0 +: CH_W];
  assign frame_end = head.frame_end;

endmodule

`default_nettype wire

// ----- hdl/c3sbf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module c3sbf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/c3sbf_kernel.sv -----
// One color channel of the sharpen and box blur kernels with clamping.
`default_nettype none

module c3sbf_kernel import c3sbf_pkg::*; (
  input  wire logic [8:0][CH_W-1:0] taps,
  input  wire logic                 mode,
  input  wire logic [CH_W-1:0]      max_color,
  output logic      [CH_W-1:0]      result
);

  logic [SUM_W-1:0]  sum9;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  center5;
  logic [SUM_W-1:0]  edges;
  logic [SUM_W-1:0]  sharp;
  logic [CH_W-1:0]   blur;

  always_comb begin
    sum9 = '0;
    for (int k = 0; k < 9; k++) begin
      sum9 = sum9 + SUM_W'(taps[k]);
    end
  end

  assign prod = PROD_W'(sum9) * PROD_W'(BLUR_RECIP);
  assign blur = prod[BLUR_SHIFT +: CH_W];

  // Taps are row-major, so the edge neighbors are 1, 3, 5 and 7.
  assign center5 = (SUM_W'(taps[4]) << 2) + SUM_W'(taps[4]);
  assign edges   = SUM_W'(taps[1]) + SUM_W'(taps[3]) + SUM_W'(taps[5]) + SUM_W'(taps[7]);
  assign sharp   = center5 - edges;

  always_comb begin
    if (mode == MODE_BLUR) begin
      result = blur;
    end else if (sharp[SUM_W-1]) begin
      result = '0;
    end else if (sharp[SUM_W-2:CH_W] != '0) begin
      result = max_color;
    end else begin
      result = sharp[CH_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/c3sbf_result_fifo.sv -----
// Four-entry result queue that takes up to two results per cycle.
`default_nettype none

module c3sbf_result_fifo import c3sbf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire push_t              push,
  input  wire logic               pop,
  output logic                    head_valid,
  output result_t                 head,
  output logic      [FIFO_CW-1:0] free_slots
);

  result_t              entry [FIFO_DEPTH];
  logic [FIFO_PW-1:0]   wr_ptr;
  logic [FIFO_PW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 do_pop;

  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];
  assign free_slots = FIFO_CW'(FIFO_DEPTH) - count;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entry[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      entry[wr_ptr + FIFO_PW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PW'(push.n);
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PW'(1);
      end
      count <= count + FIFO_CW'(push.n) - FIFO_CW'(do_pop);
    end
  end

endmodule

`default_nettype wire
